/* rtl/mals_pkg.sv */
`default_nettype none
package mals_pkg;
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int LIMIT_W = 21;
   localparam int LINE_W = 24 * 3 + 32;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_TICK  = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_ZERO     = 2'd2,
      ST_RESERVED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_DIV1  = 3'd0,
      REG_DIV2  = 3'd1,
      REG_DIV4  = 3'd2,
      REG_DIV8  = 3'd3,
      REG_DIV64 = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RDWAIT,
      S_AXIS,
      S_DIV,
      S_DIV2,
      S_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [31:0] quot;
   } div_rsp_type;

   // prescale code -> divisor minus one
   function automatic logic [7:0] presc_max(input logic [2:0] sel);
      case (sel)
         3'd0: presc_max = 8'd0;
         3'd1: presc_max = 8'd1;
         3'd2: presc_max = 8'd3;
         3'd3: presc_max = 8'd7;
         3'd4: presc_max = 8'd63;
         default: presc_max = 8'd255;
      endcase
   endfunction
endpackage
`default_nettype wire

/* rtl/mals_ram.sv */
`default_nettype none
module mals_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/mals_div.sv */
`default_nettype none
// 32/32 restoring divider, one quotient bit per cycle
module mals_div import mals_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (req.start) begin
         rem_in = '0; quo_in = req.num; den_in = req.den;
         cnt_in = 6'd32; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp.done |=> !rsp.done) else $error("divider done held");
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("divider busy with zero count");
   a_start: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff) else $error("divider did not start");
endmodule
`default_nettype wire

/* rtl/multi_axis_line_step_generator.sv */
`default_nettype none
// Three-axis line step generator. Every accepted word (push, tick, flush or
// no-op) moves from S_IDLE to S_OUT; a word that does not start a new line puts
// its result in the output register when S_OUT returns to S_IDLE, and the next
// word is taken once that result is handed off, so no new word is taken while
// one is in flight. When a line loads, each nonzero axis runs two passes of the
// shared serial divider (rate, then step count).
// Queue is a small RAM with registered read.
module multi_axis_line_step_generator import mals_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic signed [23:0] req_move_x,
   input  wire logic signed [23:0] req_move_y,
   input  wire logic signed [23:0] req_move_z,
   input  wire logic [31:0] req_duration_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_pulse_x,
   output logic             rsp_pulse_y,
   output logic             rsp_pulse_z,
   output logic [2:0]       rsp_direction_bits,
   output logic [2:0]       rsp_running_axes,
   output logic [2:0]       rsp_lines_queued,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [20:0] csr_data
);
   logic [LIMIT_W-1:0] lim_ff [5];
   state_type state_ff, state_in;
   logic [QIDX_W-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [2:0] mask_ff, mask_in, dir_ff, dir_in;
   logic [31:0] rem_ff [3], rem_in [3];
   logic [15:0] per_ff [3], per_in [3], pcnt_ff [3], pcnt_in [3];
   logic [2:0]  sel_ff [3], sel_in [3];
   logic [7:0]  scnt_ff [3], scnt_in [3];
   logic [2:0]  pulse_ff, pulse_in;
   logic [1:0]  status_ff, status_in;
   logic        ovalid_ff, ovalid_in;
   logic [1:0]  axis_ff, axis_in;
   logic [31:0] rate_ff, rate_in;
   logic [23:0] mv [3];
   logic [LINE_W-1:0] ram_rd;
   logic        ram_we;
   div_req_type dreq;
   div_rsp_type drsp;
   logic [31:0] mag, dur, rate1;
   logic [36:0] perw;
   logic [2:0]  selw;
   logic        acc;
   logic        need_load;

   assign acc = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || (ovalid_ff && rsp_stall);
   assign csr_ready = 1'b1;
   assign ram_we = acc && req_opcode == OP_PUSH &&
                   {req_move_x, req_move_y, req_move_z} != 72'd0 &&
                   fill_ff < FILL_W'(QUEUE_DEPTH);

   mals_ram #(.WIDTH(LINE_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .wr_en(ram_we), .wr_addr(wr_ff),
      .wr_data({req_move_x, req_move_y, req_move_z, req_duration_us}),
      .rd_addr(rd_ff), .rd_data(ram_rd));

   mals_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign mv[0] = ram_rd[103:80];
   assign mv[1] = ram_rd[79:56];
   assign mv[2] = ram_rd[55:32];
   assign dur   = ram_rd[31:0];
   assign mag   = mv[axis_ff][23] ? 32'(-{8'd0, mv[axis_ff]} & 32'hFFFFFF) |
                  {31'd0, mv[axis_ff] == 24'h800000} << 23 : {8'd0, mv[axis_ff]};
   assign rate1 = drsp.quot == 32'd0 ? 32'd1 : drsp.quot;

   always_comb begin
      if (rate_ff < {11'd0, lim_ff[0]})      begin selw = 3'd0; perw = {rate_ff, 5'd0}; end
      else if (rate_ff < {11'd0, lim_ff[1]}) begin selw = 3'd1; perw = {1'b0, rate_ff, 4'd0}; end
      else if (rate_ff < {11'd0, lim_ff[2]}) begin selw = 3'd2; perw = {2'd0, rate_ff, 3'd0}; end
      else if (rate_ff < {11'd0, lim_ff[3]}) begin selw = 3'd3; perw = {3'd0, rate_ff, 2'd0}; end
      else if (rate_ff < {11'd0, lim_ff[4]}) begin selw = 3'd4; perw = {6'd0, rate_ff[31:1]}; end
      else                                   begin selw = 3'd5; perw = {8'd0, rate_ff[31:3]}; end
   end

   always_comb begin
      state_in = state_ff; rd_in = rd_ff; wr_in = wr_ff; fill_in = fill_ff;
      mask_in = mask_ff; dir_in = dir_ff; pulse_in = pulse_ff;
      status_in = status_ff; ovalid_in = ovalid_ff && rsp_stall;
      axis_in = axis_ff; rate_in = rate_ff;
      rem_in = rem_ff; per_in = per_ff; pcnt_in = pcnt_ff;
      sel_in = sel_ff; scnt_in = scnt_ff;
      dreq = '0;
      need_load = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               pulse_in = 3'd0; status_in = ST_OK;
               case (req_opcode)
                  OP_PUSH: begin
                     if ({req_move_x, req_move_y, req_move_z} == 72'd0)
                        status_in = ST_ZERO;
                     else if (fill_ff >= FILL_W'(QUEUE_DEPTH)) status_in = ST_FULL;
                     else begin
                        wr_in = (wr_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  OP_TICK: begin
                     for (int a = 0; a < 3; a++) begin
                        if (mask_ff[a]) begin
                           if (scnt_ff[a] < presc_max(sel_ff[a]))
                              scnt_in[a] = scnt_ff[a] + 8'd1;
                           else begin
                              scnt_in[a] = 8'd0;
                              if (pcnt_ff[a] < per_ff[a]) pcnt_in[a] = pcnt_ff[a] + 16'd1;
                              else begin
                                 pcnt_in[a] = 16'd0;
                                 pulse_in[a] = 1'b1;
                                 rem_in[a] = rem_ff[a] - 32'd1;
                                 if (rem_ff[a] == 32'd1) mask_in[a] = 1'b0;
                              end
                           end
                        end
                     end
                  end
                  OP_FLUSH: begin
                     rd_in = wr_ff; fill_in = '0;
                  end
                  default: ;
               endcase
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // queue head RAM read is registered this cycle and used in S_RDWAIT if we load
            need_load = mask_ff == 3'd0 && fill_ff != '0;
            if (need_load) begin
               state_in = S_RDWAIT;
            end else begin
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RDWAIT: begin
            fill_in = fill_ff - 1'b1;
            dir_in = {mv[2][23], mv[1][23], mv[0][23]};
            axis_in = 2'd0;
            state_in = S_AXIS;
         end
         S_AXIS: begin
            // read address holds until the whole line is set up
            if (axis_ff == 2'd3) begin
               rd_in = (rd_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
               ovalid_in = 1'b1;
               state_in = S_IDLE;
            end else if (mv[axis_ff] == 24'd0) begin
               axis_in = axis_ff + 2'd1;
            end else begin
               dreq.start = 1'b1; dreq.num = dur; dreq.den = mag;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (drsp.done) begin
               rate_in = rate1;
               dreq.start = 1'b1; dreq.num = dur; dreq.den = rate1;
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (drsp.done) begin
               rem_in[axis_ff] = drsp.quot == 32'd0 ? 32'd1 : drsp.quot;
               per_in[axis_ff] = perw > 37'hFFFF ? 16'hFFFF : perw[15:0];
               sel_in[axis_ff] = selw;
               scnt_in[axis_ff] = 8'd0;
               pcnt_in[axis_ff] = 16'd0;
               mask_in[axis_ff] = 1'b1;
               axis_in = axis_ff + 2'd1;
               state_in = S_AXIS;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rd_ff <= '0; wr_ff <= '0; fill_ff <= '0;
         mask_ff <= '0; dir_ff <= '0; ovalid_ff <= 1'b0;
         lim_ff[0] <= 21'd2048; lim_ff[1] <= 21'd4096; lim_ff[2] <= 21'd8192;
         lim_ff[3] <= 21'd16384; lim_ff[4] <= 21'd131072;
         for (int a = 0; a < 3; a++) begin
            rem_ff[a] <= '0; per_ff[a] <= '0; pcnt_ff[a] <= '0;
            sel_ff[a] <= '0; scnt_ff[a] <= '0;
         end
      end else begin
         state_ff <= state_in; rd_ff <= rd_in; wr_ff <= wr_in; fill_ff <= fill_in;
         mask_ff <= mask_in; dir_ff <= dir_in; ovalid_ff <= ovalid_in;
         rem_ff <= rem_in; per_ff <= per_in; pcnt_ff <= pcnt_in;
         sel_ff <= sel_in; scnt_ff <= scnt_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_DIV1:  lim_ff[0] <= csr_data;
               REG_DIV2:  lim_ff[1] <= csr_data;
               REG_DIV4:  lim_ff[2] <= csr_data;
               REG_DIV8:  lim_ff[3] <= csr_data;
               REG_DIV64: lim_ff[4] <= csr_data;
               default: ;
            endcase
         end
      end
      pulse_ff <= pulse_in; status_ff <= status_in;
      axis_ff <= axis_in; rate_ff <= rate_in;
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_pulse_x = pulse_ff[0];
   assign rsp_pulse_y = pulse_ff[1];
   assign rsp_pulse_z = pulse_ff[2];
   assign rsp_direction_bits = dir_ff;
   assign rsp_running_axes = mask_ff;
   assign rsp_lines_queued = 3'(fill_ff);
   assign rsp_status = status_ff;

   a_fill: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall) else $error("took word while busy");
   a_load_active: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_AXIS && axis_ff == 2'd3 |-> mask_ff != 3'd0)
      else $error("loaded line has no active axis");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("word dropped");
endmodule
`default_nettype wire

/* tb/sv/multi_axis_line_step_generator_tb.sv */
`default_nettype none
module multi_axis_line_step_generator_tb;
   import mals_pkg::*;

   typedef struct packed {
      logic       px;
      logic       py;
      logic       pz;
      logic [2:0] dir;
      logic [2:0] act;
      logic [2:0] lines;
      status_type st;
   } step_word_t;

   typedef struct {
      opcode_type  op;
      logic [23:0] mx, my, mz;
      logic [31:0] dur;
      bit          typed;
      step_word_t  want;
   } stim_row_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_opcode = 0;
   logic signed [23:0] req_move_x = 0, req_move_y = 0, req_move_z = 0;
   logic [31:0] req_duration_us = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_pulse_x, rsp_pulse_y, rsp_pulse_z;
   logic [2:0] rsp_direction_bits, rsp_running_axes, rsp_lines_queued;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [2:0] csr_index = 0;
   logic [20:0] csr_data = 0;

   multi_axis_line_step_generator uut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [20:0] lim [5];
   logic [23:0] q_x [QUEUE_DEPTH], q_y [QUEUE_DEPTH], q_z [QUEUE_DEPTH];
   logic [31:0] q_time [QUEUE_DEPTH];
   int unsigned rd_ptr, wr_ptr, fill;
   logic [2:0] run_mask, run_dir;
   logic [31:0] steps_left [3];
   logic [15:0] period_val [3], period_cnt [3];
   int unsigned presc_code [3];
   logic [7:0] presc_cnt [3];

   step_word_t expected_words [$];
   int errors = 0;
   bit send_burst = 0, recv_burst = 0;

   function automatic int unsigned presc_divisor(int unsigned code);
      case (code)
         0: return 1;
         1: return 2;
         2: return 4;
         3: return 8;
         4: return 64;
         default: return 256;
      endcase
   endfunction

   task automatic load_axis(int a, logic [31:0] mag, logic [31:0] dur);
      logic [31:0] rate, cnt;
      logic [63:0] per;
      int unsigned code;
      rate = dur / mag;
      if (rate == 0) rate = 1;
      if (rate < lim[0]) begin code = 0; per = 64'(rate) * 32; end
      else if (rate < lim[1]) begin code = 1; per = 64'(rate) * 16; end
      else if (rate < lim[2]) begin code = 2; per = 64'(rate) * 8; end
      else if (rate < lim[3]) begin code = 3; per = 64'(rate) * 4; end
      else if (rate < lim[4]) begin code = 4; per = 64'(rate) / 2; end
      else begin code = 5; per = 64'(rate) / 8; end
      cnt = dur / rate;
      if (cnt == 0) cnt = 1;
      if (per > 64'hFFFF) per = 64'hFFFF;
      steps_left[a] = cnt;
      period_val[a] = per[15:0];
      presc_code[a] = code;
      presc_cnt[a] = 0;
      period_cnt[a] = 0;
      run_mask[a] = 1'b1;
   endtask

   task automatic load_line();
      logic [23:0] mv [3];
      logic [31:0] mag;
      if (run_mask != 0 || fill == 0) return;
      mv[0] = q_x[rd_ptr];
      mv[1] = q_y[rd_ptr];
      mv[2] = q_z[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      fill--;
      run_dir = 0;
      for (int a = 0; a < 3; a++) begin
         run_dir[a] = mv[a][23];
         if (mv[a] != 0) begin
            mag = mv[a][23] ? 32'(25'h1000000 - 25'(mv[a])) : 32'(mv[a]);
            load_axis(a, mag, q_time[(rd_ptr + QUEUE_DEPTH - 1) % QUEUE_DEPTH]);
         end
      end
   endtask

   task automatic step_model(input opcode_type op, input logic [23:0] mx, my, mz,
                             input logic [31:0] dur, output step_word_t w);
      logic [2:0] pulses;
      status_type st;
      pulses = 0;
      st = ST_OK;
      case (op)
         OP_PUSH: begin
            if (mx == 0 && my == 0 && mz == 0) st = ST_ZERO;
            else if (fill >= QUEUE_DEPTH) st = ST_FULL;
            else begin
               q_x[wr_ptr] = mx;
               q_y[wr_ptr] = my;
               q_z[wr_ptr] = mz;
               q_time[wr_ptr] = dur;
               wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
               fill++;
            end
         end
         OP_TICK: begin
            for (int a = 0; a < 3; a++) begin
               if (!run_mask[a]) continue;
               if (presc_cnt[a] + 1 < presc_divisor(presc_code[a])) begin
                  presc_cnt[a]++;
                  continue;
               end
               presc_cnt[a] = 0;
               if (period_cnt[a] < period_val[a]) begin
                  period_cnt[a]++;
                  continue;
               end
               period_cnt[a] = 0;
               pulses[a] = 1'b1;
               steps_left[a]--;
               if (steps_left[a] == 0) run_mask[a] = 1'b0;
            end
         end
         OP_FLUSH: begin
            rd_ptr = wr_ptr;
            fill = 0;
         end
         default: ;
      endcase
      load_line();
      w = '{px: pulses[0], py: pulses[1], pz: pulses[2], dir: run_dir, act: run_mask,
            lines: 3'(fill), st: st};
   endtask

   task automatic send_word(opcode_type op, logic [23:0] mx, my, mz, logic [31:0] dur,
                            bit typed = 0, step_word_t want = '0);
      int gap;
      step_word_t w;
      gap = send_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_move_x <= mx;
      req_move_y <= my;
      req_move_z <= mz;
      req_duration_us <= dur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_model(op, mx, my, mz, dur, w);
      expected_words.push_back(typed ? want : w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(reg_index_type idx, logic [20:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      lim[idx] = val;
   endtask

   task automatic set_limits(logic [20:0] l1, l2, l4, l8, l64);
      write_limit(REG_DIV1, l1);
      write_limit(REG_DIV2, l2);
      write_limit(REG_DIV4, l4);
      write_limit(REG_DIV8, l8);
      write_limit(REG_DIV64, l64);
   endtask

   function automatic logic [23:0] small_move();
      int s;
      s = $urandom_range(0, 3);
      return $urandom_range(0, 1) ? -24'(s) : 24'(s);
   endfunction

   task automatic tick_until_idle(int cap);
      for (int i = 0; i < cap && (run_mask != 0 || fill != 0); i++)
         send_word(OP_TICK, 0, 0, 0, $urandom);
   endtask

   task automatic random_phase(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 4)) begin
            send_word(OP_PUSH, small_move(), small_move(), small_move(),
                      $urandom_range(0, 12));
            sent++;
         end
         case ($urandom_range(0, 5))
            0: if (run_mask != 0) begin
               // wild line while another runs, flushed before it can load
               send_word(OP_PUSH, 24'($urandom), 24'($urandom), 24'($urandom), $urandom);
               send_word(OP_FLUSH, 24'($urandom), 24'($urandom), 24'($urandom), $urandom);
               sent += 2;
            end
            1: begin
               send_word(opcode_type'($urandom_range(2, 3)), 24'($urandom),
                         24'($urandom), 24'($urandom), $urandom);
               sent++;
            end
            2: begin
               send_word(OP_PUSH, 0, 0, 0, $urandom);
               sent++;
            end
            default: ;
         endcase
         repeat ($urandom_range(0, 20)) begin
            send_word(OP_TICK, 24'($urandom), 24'($urandom), 24'($urandom), $urandom);
            sent++;
         end
      end
      tick_until_idle(15);
   endtask

   // result side: random stall, then compare with the oldest expectation
   int stall_left = 0;
   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      step_word_t w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word expected none actual %0h", $time,
                     {rsp_pulse_x, rsp_pulse_y, rsp_pulse_z, rsp_direction_bits,
                      rsp_running_axes, rsp_lines_queued, rsp_status});
            errors++;
         end else begin
            w = expected_words.pop_front();
            check_field("pulse_x", w.px, rsp_pulse_x);
            check_field("pulse_y", w.py, rsp_pulse_y);
            check_field("pulse_z", w.pz, rsp_pulse_z);
            check_field("direction_bits", w.dir, rsp_direction_bits);
            check_field("running_axes", w.act, rsp_running_axes);
            check_field("lines_queued", w.lines, rsp_lines_queued);
            check_field("status", w.st, rsp_status);
         end
         stall_left = recv_burst ? 0 : $urandom_range(0, 12);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   stim_row_t directed [$];

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      step_word_t idle_ok;
      idle_ok = '0;
      lim[0] = 2048; lim[1] = 4096; lim[2] = 8192; lim[3] = 16384; lim[4] = 131072;
      rd_ptr = 0; wr_ptr = 0; fill = 0; run_mask = 0; run_dir = 0;
      for (int a = 0; a < 3; a++) begin
         steps_left[a] = 0; period_val[a] = 0; period_cnt[a] = 0;
         presc_code[a] = 0; presc_cnt[a] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      directed.push_back('{OP_TICK, 0, 0, 0, 0, 1, idle_ok});
      directed.push_back('{OP_PUSH, 0, 0, 0, 32'hFFFFFFFF, 1,
                           '{0, 0, 0, 0, 0, 0, ST_ZERO}});
      directed.push_back('{OP_NONE, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 32'hFFFFFFFF,
                           1, idle_ok});
      directed.push_back('{OP_FLUSH, 0, 0, 0, 0, 1, idle_ok});
      directed.push_back('{OP_PUSH, 1, 0, 0, 0, 0, idle_ok});
      directed.push_back('{OP_PUSH, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 32'hFFFFFFFF,
                           0, idle_ok});
      directed.push_back('{OP_PUSH, 24'h800000, 0, 1, 0, 0, idle_ok});
      directed.push_back('{OP_PUSH, 0, 24'h555555, 0, 32'h80000000, 0, idle_ok});
      directed.push_back('{OP_PUSH, 0, 0, 24'h2AAAAA, 32'h7FFFFFFF, 0, idle_ok});
      directed.push_back('{OP_PUSH, 5, 5, 5, 5, 1,
                           '{0, 0, 0, 3'b000, 3'b001, 3'd4, ST_FULL}});
      directed.push_back('{OP_FLUSH, 0, 0, 0, 0, 1,
                           '{0, 0, 0, 3'b000, 3'b001, 3'd0, ST_OK}});
      directed.push_back('{OP_PUSH, 24'hFFFFFE, 3, 24'hFFFFFF, 0, 0, idle_ok});
      directed.push_back('{OP_PUSH, 2, 0, 0, 7, 0, idle_ok});
      foreach (directed[i])
         send_word(directed[i].op, directed[i].mx, directed[i].my, directed[i].mz,
                   directed[i].dur, directed[i].typed, directed[i].want);
      tick_until_idle(40);
      drain();

      // default limits
      random_phase(50);
      drain();
      set_limits(1, 2, 3, 4, 5);
      random_phase(50);
      drain();
      set_limits(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF);
      random_phase(50);
      drain();
      // everything on the slowest prescaler, period is the rate divided by eight
      set_limits(1, 1, 1, 1, 1);
      random_phase(50);
      drain();
      set_limits(21'($urandom_range(1, 4)), 21'($urandom_range(1, 6)),
                 21'($urandom_range(1, 8)), 21'($urandom_range(1, 10)),
                 21'($urandom_range(1, 2097151)));
      random_phase(50);
      drain();

      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
`default_nettype wire
